>>> sv/assert_macros.svh
// assert_macros.svh: assertion macros shared by the observer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked property, disabled while reset is asserted
`define SSO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("observer assertion failed");
// clocked property, checked also during reset
`define SSO_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("observer assertion failed");
`else
`define SSO_ASSERT(lbl, clk, rstn, prop)
`define SSO_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/sso_pkg.sv
// sso_pkg: types, coefficients and fixed-point helpers of the state observer
// no dependencies; used by sso_chan and steady_state_state_observer_unit
`default_nettype none
package sso_pkg;

  localparam int DATA_W = 32;
  localparam int COEF_W = 20;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 54;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_w_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // coefficient set of one two-state channel, each round(value * 2^16)
  typedef struct packed {
    coef_w_t cv;   // velocity output gain
    coef_w_t cp;   // position output gain on state
    coef_w_t dp;   // position output gain on measurement
    coef_w_t a11;
    coef_w_t a12;
    coef_w_t b1;
    coef_w_t a21;
    coef_w_t a22;
    coef_w_t b2;
    coef_w_t g2;
  } coef_t;

  localparam coef_t COEF_X = '{cv: 20'sd23403, cp: 20'sd49191, dp: 20'sd16345,
                               a11: 20'sd65149, a12: 20'sd23265, b1: 20'sd2998,
                               a21: 20'sd6534, a22: 20'sd46858, b2: 20'sd151,
                               g2: 20'sd18678};
  localparam coef_t COEF_Y = '{cv: 20'sd26070, cp: 20'sd48352, dp: 20'sd17184,
                               a11: 20'sd65202, a12: 20'sd25919, b1: 20'sd2998,
                               a21: 20'sd6534, a22: 20'sd45757, b2: 20'sd151,
                               g2: 20'sd19779};
  localparam coef_t COEF_H = '{cv: 20'sd125108, cp: 20'sd31333, dp: 20'sd34203,
                               a11: 20'sd54821, a12: 20'sd104661, b1: 20'sd214368,
                               a21: 20'sd6002, a22: 20'sd19877, b2: 20'sd11036,
                               g2: 20'sd45659};

  localparam coef_w_t K_ONE      = 20'sd65536;
  localparam acc_t    ROUND_HALF = 54'sd32768;

  // exact product of a q16.16 word and a coefficient, 32 fraction bits
  function automatic acc_t mul_k(input data_t a, input coef_w_t k);
    acc_t p;
    p = acc_t'(a) * acc_t'(k);
    return p;
  endfunction

  // round half up to 16 fraction bits and clamp to the 32-bit range
  function automatic data_t finish(input acc_t acc);
    acc_t r;
    acc_t q;
    data_t res;
    r = acc + ROUND_HALF;
    q = r >>> FRAC_W;
    if (!q[ACC_W-1] && (|q[ACC_W-2:DATA_W-1])) begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (q[ACC_W-1] && !(&q[ACC_W-2:DATA_W-1])) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = q[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/sso_chan.sv
// sso_chan: one two-state observer channel (estimate register plus update)
// depends on sso_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module sso_chan (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           upd,
  input  wire sso_pkg::coef_t coef,
  input  wire sso_pkg::data_t meas,
  input  wire sso_pkg::data_t frc,
  output sso_pkg::data_t      vel,
  output sso_pkg::data_t      pos
);

  sso_pkg::data_t s0_r, s1_r;
  sso_pkg::data_t s0_nxt, s1_nxt;

  // output equation from the estimate before the update
  always_comb begin
    vel = sso_pkg::finish(sso_pkg::mul_k(s0_r, sso_pkg::K_ONE)
                          - sso_pkg::mul_k(s1_r, coef.cv)
                          + sso_pkg::mul_k(meas, coef.cv));
    pos = sso_pkg::finish(sso_pkg::mul_k(s1_r, coef.cp)
                          + sso_pkg::mul_k(meas, coef.dp));
  end

  // estimate update: a*xhat + b*u + g*z
  always_comb begin
    s0_nxt = sso_pkg::finish(sso_pkg::mul_k(s0_r, coef.a11)
                             - sso_pkg::mul_k(s1_r, coef.a12)
                             + sso_pkg::mul_k(frc, coef.b1)
                             + sso_pkg::mul_k(meas, coef.a12));
    s1_nxt = sso_pkg::finish(sso_pkg::mul_k(s0_r, coef.a21)
                             + sso_pkg::mul_k(s1_r, coef.a22)
                             + sso_pkg::mul_k(frc, coef.b2)
                             + sso_pkg::mul_k(meas, coef.g2));
  end

  // estimate register, advances once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      s1_r <= '0;
    end else if (upd) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
    end
  end

  // estimate only moves on an update
  `SSO_ASSERT(a_hold_est, clk, rst_n, !upd |=> $stable(s0_r) && $stable(s1_r))
  // zero estimate with zero inputs stays at zero
  `SSO_ASSERT(a_zero_fixed, clk, rst_n,
    upd && s0_r == '0 && s1_r == '0 && meas == '0 && frc == '0 |=>
    s0_r == '0 && s1_r == '0)
  // zero estimate and zero measurement give zero outputs
  `SSO_ASSERT(a_zero_vel, clk, rst_n,
    s0_r == '0 && s1_r == '0 && meas == '0 |-> vel == '0 && pos == '0)

endmodule
`default_nettype wire

>>> sv/steady_state_state_observer_unit.sv
// Usage notes for steady_state_state_observer_unit
// Fixed-gain observer for a planar vehicle with three decoupled channels
// (x, y, heading). Input transaction: measured x, y, heading and the applied
// force x, force y and yaw torque, all signed q16.16. Output transaction: the
// velocity and position estimate of each channel, signed q16.16, saturated.
// Both channels use valid/stall; a transaction moves on an edge with valid
// high and stall low. A transaction accepted at an edge sits in the input
// register and moves on into the result register, raising out_valid, once
// the result register is free or being taken. One transaction per cycle is
// sustained while the receiver does not stall; the limit is the estimate
// update loop, a combinational four-term constant multiply-add with rounding.
// When the receiver stalls the result register holds; the input register
// keeps taking one more transaction, after which in_stall rises.
// Synchronous reset (rst_n low) clears the estimates to zero and drops both
// valid flags.
// depends on sso_pkg, sso_chan and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module steady_state_state_observer_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sso_pkg::data_t in_meas_x,
  input  wire sso_pkg::data_t in_meas_y,
  input  wire sso_pkg::data_t in_meas_heading,
  input  wire sso_pkg::data_t in_force_x,
  input  wire sso_pkg::data_t in_force_y,
  input  wire sso_pkg::data_t in_torque_z,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sso_pkg::data_t      out_est_vel_x,
  output sso_pkg::data_t      out_est_pos_x,
  output sso_pkg::data_t      out_est_vel_y,
  output sso_pkg::data_t      out_est_pos_y,
  output sso_pkg::data_t      out_est_heading_rate,
  output sso_pkg::data_t      out_est_heading
);

  logic           in_vld_r, in_vld_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic           adv;
  sso_pkg::data_t mx_r, my_r, mh_r, fx_r, fy_r, tz_r;
  sso_pkg::data_t vx, px, vy, py, vh, ph;
  sso_pkg::data_t vx_r, px_r, vy_r, py_r, vh_r, ph_r;

  // handshake: the input stage moves when the result register is free
  assign adv         = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall    = in_vld_r && out_vld_r && out_stall;
  assign in_vld_nxt  = in_stall ? in_vld_r : in_valid;
  assign out_vld_nxt = adv ? 1'b1 : (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      mx_r <= in_meas_x;
      my_r <= in_meas_y;
      mh_r <= in_meas_heading;
      fx_r <= in_force_x;
      fy_r <= in_force_y;
      tz_r <= in_torque_z;
    end
  end

  // observer channels
  sso_chan u_chan_x (
    .clk(clk), .rst_n(rst_n), .upd(adv), .coef(sso_pkg::COEF_X),
    .meas(mx_r), .frc(fx_r), .vel(vx), .pos(px)
  );
  sso_chan u_chan_y (
    .clk(clk), .rst_n(rst_n), .upd(adv), .coef(sso_pkg::COEF_Y),
    .meas(my_r), .frc(fy_r), .vel(vy), .pos(py)
  );
  sso_chan u_chan_h (
    .clk(clk), .rst_n(rst_n), .upd(adv), .coef(sso_pkg::COEF_H),
    .meas(mh_r), .frc(tz_r), .vel(vh), .pos(ph)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r <= vx;
      px_r <= px;
      vy_r <= vy;
      py_r <= py;
      vh_r <= vh;
      ph_r <= ph;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_est_vel_x        = vx_r;
  assign out_est_pos_x        = px_r;
  assign out_est_vel_y        = vy_r;
  assign out_est_pos_y        = py_r;
  assign out_est_heading_rate = vh_r;
  assign out_est_heading      = ph_r;

  // an advancing transaction always lands in the result register
  `SSO_ASSERT(a_adv_lands, clk, rst_n, adv |=> out_vld_r)
  // an accepted transaction is held in the input stage
  `SSO_ASSERT(a_in_held, clk, rst_n, in_valid && !in_stall |=> in_vld_r)
  // a taken result with nothing behind it empties the result register
  `SSO_ASSERT(a_out_drain, clk, rst_n,
    out_vld_r && !out_stall && !in_vld_r |=> !out_vld_r)
  // a held input transaction stays put until it advances
  `SSO_ASSERT(a_in_wait, clk, rst_n, in_vld_r && !adv |=> in_vld_r && $stable(mx_r))

endmodule
`default_nettype wire
